// ----- src/ilac_pkg.sv -----
// Shared types, constants and the micro-operation table for lever-arm compensation.
package ilac_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int FIELD_W  = 32;
  localparam int OFFSET_W = 20;
  localparam int HZ_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam logic [HZ_W-1:0] HZ_RESET = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_HZ  = 2'd3;

  localparam int NUM_STEPS = 21;
  localparam int STEP_W    = 5;

  typedef struct packed {
    logic signed [FIELD_W-1:0] accel_x;
    logic signed [FIELD_W-1:0] accel_y;
    logic signed [FIELD_W-1:0] accel_z;
    logic signed [FIELD_W-1:0] rate_x;
    logic signed [FIELD_W-1:0] rate_y;
    logic signed [FIELD_W-1:0] rate_z;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] comp_accel_x;
    logic signed [FIELD_W-1:0] comp_accel_y;
    logic signed [FIELD_W-1:0] comp_accel_z;
    logic signed [FIELD_W-1:0] ang_accel_x;
    logic signed [FIELD_W-1:0] ang_accel_y;
    logic signed [FIELD_W-1:0] ang_accel_z;
  } out_item_t;

  typedef enum logic [1:0] {
    A_DIFF  = 2'd0,
    A_RATE  = 2'd1,
    A_ALPHA = 2'd2
  } a_sel_e;

  typedef enum logic [1:0] {
    B_HZ  = 2'd0,
    B_OFS = 2'd1,
    B_WR  = 2'd2
  } b_sel_e;

  typedef enum logic [2:0] {
    K_ALPHA = 3'd0,
    K_TMP   = 3'd1,
    K_WR    = 3'd2,
    K_SUB   = 3'd3,
    K_ADD   = 3'd4
  } kind_e;

  typedef struct packed {
    a_sel_e      a_sel;
    logic [1:0]  a_idx;
    b_sel_e      b_sel;
    logic [1:0]  b_idx;
    kind_e       kind;
    logic [1:0]  dst;
  } uop_t;

  typedef struct packed {
    logic              load;
    logic              issue;
    logic [STEP_W-1:0] step;
    logic              finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  function automatic uop_t mk_uop(input a_sel_e a, input logic [1:0] ai, input b_sel_e b,
                                  input logic [1:0] bi, input kind_e k, input logic [1:0] d);
    uop_t u;
    u.a_sel = a;
    u.a_idx = ai;
    u.b_sel = b;
    u.b_idx = bi;
    u.kind  = k;
    u.dst   = d;
    return u;
  endfunction

  // alpha, omega x r, alpha x r, omega x (omega x r)
  function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
    uop_t u;
    case (step)
      5'd0:  u = mk_uop(A_DIFF, 2'd0, B_HZ, 2'd0, K_ALPHA, 2'd0);
      5'd1:  u = mk_uop(A_DIFF, 2'd1, B_HZ, 2'd0, K_ALPHA, 2'd1);
      5'd2:  u = mk_uop(A_DIFF, 2'd2, B_HZ, 2'd0, K_ALPHA, 2'd2);
      5'd3:  u = mk_uop(A_RATE, 2'd1, B_OFS, 2'd2, K_TMP, 2'd0);
      5'd4:  u = mk_uop(A_RATE, 2'd2, B_OFS, 2'd1, K_WR, 2'd0);
      5'd5:  u = mk_uop(A_RATE, 2'd2, B_OFS, 2'd0, K_TMP, 2'd1);
      5'd6:  u = mk_uop(A_RATE, 2'd0, B_OFS, 2'd2, K_WR, 2'd1);
      5'd7:  u = mk_uop(A_RATE, 2'd0, B_OFS, 2'd1, K_TMP, 2'd2);
      5'd8:  u = mk_uop(A_RATE, 2'd1, B_OFS, 2'd0, K_WR, 2'd2);
      5'd9:  u = mk_uop(A_ALPHA, 2'd1, B_OFS, 2'd2, K_SUB, 2'd0);
      5'd10: u = mk_uop(A_ALPHA, 2'd2, B_OFS, 2'd1, K_ADD, 2'd0);
      5'd11: u = mk_uop(A_ALPHA, 2'd2, B_OFS, 2'd0, K_SUB, 2'd1);
      5'd12: u = mk_uop(A_ALPHA, 2'd0, B_OFS, 2'd2, K_ADD, 2'd1);
      5'd13: u = mk_uop(A_ALPHA, 2'd0, B_OFS, 2'd1, K_SUB, 2'd2);
      5'd14: u = mk_uop(A_ALPHA, 2'd1, B_OFS, 2'd0, K_ADD, 2'd2);
      5'd15: u = mk_uop(A_RATE, 2'd1, B_WR, 2'd2, K_SUB, 2'd0);
      5'd16: u = mk_uop(A_RATE, 2'd2, B_WR, 2'd1, K_ADD, 2'd0);
      5'd17: u = mk_uop(A_RATE, 2'd2, B_WR, 2'd0, K_SUB, 2'd1);
      5'd18: u = mk_uop(A_RATE, 2'd0, B_WR, 2'd2, K_ADD, 2'd1);
      5'd19: u = mk_uop(A_RATE, 2'd0, B_WR, 2'd1, K_SUB, 2'd2);
      5'd20: u = mk_uop(A_RATE, 2'd1, B_WR, 2'd0, K_ADD, 2'd2);
      default: u = mk_uop(A_DIFF, 2'd0, B_HZ, 2'd0, K_ALPHA, 2'd0);
    endcase
    return u;
  endfunction

endpackage

// ----- src/ilac_if.sv -----
// Valid/ready channel interfaces for sample sets and compensated results.
interface ilac_in_if;
  logic               valid;
  logic               ready;
  ilac_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ilac_out_if;
  logic                valid;
  logic                ready;
  ilac_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/ilac_ctrl.sv -----
// Sequencer that steps the shared multiplier through one sample set.
module ilac_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ilac_pkg::dp_stat_t   stat_i,
  output ilac_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e                      state_q, state_d;
  logic [ilac_pkg::STEP_W-1:0] step_q, step_d;

  localparam logic [ilac_pkg::STEP_W-1:0] LastStep = ilac_pkg::STEP_W'(ilac_pkg::NUM_STEPS - 1);

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    in_ready_o   = 1'b0;
    cmd_o.load   = 1'b0;
    cmd_o.issue  = 1'b0;
    cmd_o.step   = step_q;
    cmd_o.finish = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.issue = 1'b1;
        step_d      = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_RUN && step_q == '0))
    else $error("transaction accepted without starting the sequence");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (step_q <= LastStep))
    else $error("step counter beyond the micro-operation table");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !stat_i.out_busy)
    else $error("result written over a pending transaction");

endmodule

// ----- src/ilac_dp.sv -----
// Datapath: configuration, rate history, shared multiplier, accumulators, result register.
module ilac_dp #(
  parameter int DATA_WIDTH = ilac_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = ilac_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ilac_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ilac_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  ilac_pkg::in_item_t                 in_data_i,
  input  ilac_pkg::ctrl_cmd_t                cmd_i,
  output ilac_pkg::dp_stat_t                 stat_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output ilac_pkg::out_item_t                out_data_o
);

  localparam int SatW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam logic signed [63:0] SatHi = (64'sd1 <<< (SatW - 1)) - 64'sd1;
  localparam logic signed [63:0] SatLo = -SatHi - 64'sd1;
  localparam logic signed [63:0] Half  = 64'sd1 <<< (FRAC_BITS - 1);

  function automatic logic signed [31:0] sat(input logic signed [63:0] x);
    logic signed [63:0] y;
    if (x > SatHi) begin
      y = SatHi;
    end else if (x < SatLo) begin
      y = SatLo;
    end else begin
      y = x;
    end
    return y[31:0];
  endfunction

  logic signed [ilac_pkg::OFFSET_W-1:0] ofs_q [0:2];
  logic [ilac_pkg::HZ_W-1:0]            hz_q;
  logic signed [31:0]                   prev_q [0:2];
  logic signed [32:0]                   diff_q [0:2];
  logic signed [31:0]                   alpha_q [0:2];
  logic signed [31:0]                   wr_q [0:2];
  logic signed [63:0]                   tot_q [0:2];
  logic signed [63:0]                   tmp_q;
  logic signed [63:0]                   prod_q;
  logic                                 first_q;
  logic                                 first_item_q;
  logic                                 pend_q;
  ilac_pkg::uop_t                       pend_uop_q;
  logic                                 out_valid_q;
  ilac_pkg::out_item_t                  out_q;

  ilac_pkg::uop_t     uop;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [63:0] rnd;
  logic signed [31:0] in_rate [0:2];
  logic signed [31:0] in_acc [0:2];

  assign in_rate[0] = in_data_i.rate_x;
  assign in_rate[1] = in_data_i.rate_y;
  assign in_rate[2] = in_data_i.rate_z;
  assign in_acc[0]  = in_data_i.accel_x;
  assign in_acc[1]  = in_data_i.accel_y;
  assign in_acc[2]  = in_data_i.accel_z;

  assign uop = ilac_pkg::uop_at(cmd_i.step);

  always_comb begin
    case (uop.a_sel)
      ilac_pkg::A_DIFF:  mul_a = diff_q[uop.a_idx];
      ilac_pkg::A_RATE:  mul_a = 33'(prev_q[uop.a_idx]);
      ilac_pkg::A_ALPHA: mul_a = 33'(alpha_q[uop.a_idx]);
      default:           mul_a = '0;
    endcase
    case (uop.b_sel)
      ilac_pkg::B_HZ:  mul_b = $signed({17'd0, hz_q});
      ilac_pkg::B_OFS: mul_b = 33'(ofs_q[uop.b_idx]);
      ilac_pkg::B_WR:  mul_b = 33'(wr_q[uop.b_idx]);
      default:         mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign rnd   = (prod_q + Half) >>> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        ofs_q[i]  <= '0;
        prev_q[i] <= '0;
      end
      hz_q    <= ilac_pkg::HZ_RESET;
      first_q <= 1'b1;
      pend_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ilac_pkg::CFG_OFFSET_X: ofs_q[0] <= cfg_data_i;
          ilac_pkg::CFG_OFFSET_Y: ofs_q[1] <= cfg_data_i;
          ilac_pkg::CFG_OFFSET_Z: ofs_q[2] <= cfg_data_i;
          ilac_pkg::CFG_RATE_HZ:  hz_q     <= cfg_data_i[ilac_pkg::HZ_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        for (int i = 0; i < 3; i++) begin
          prev_q[i] <= in_rate[i];
        end
        first_q <= 1'b0;
      end
      pend_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) begin
        diff_q[i] <= 33'(in_rate[i]) - 33'(prev_q[i]);
        tot_q[i]  <= 64'(in_acc[i]);
      end
      first_item_q <= first_q;
    end
    if (cmd_i.issue) begin
      prod_q     <= mul_p[63:0];
      pend_uop_q <= uop;
    end
    if (pend_q) begin
      case (pend_uop_q.kind)
        ilac_pkg::K_ALPHA: alpha_q[pend_uop_q.dst] <= first_item_q ? '0 : sat(prod_q);
        ilac_pkg::K_TMP:   tmp_q <= rnd;
        ilac_pkg::K_WR:    wr_q[pend_uop_q.dst] <= sat(tmp_q - rnd);
        ilac_pkg::K_SUB:   tot_q[pend_uop_q.dst] <= tot_q[pend_uop_q.dst] - rnd;
        ilac_pkg::K_ADD:   tot_q[pend_uop_q.dst] <= tot_q[pend_uop_q.dst] + rnd;
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      out_q.comp_accel_x <= sat(tot_q[0]);
      out_q.comp_accel_y <= sat(tot_q[1]);
      out_q.comp_accel_z <= sat(tot_q[2]);
      out_q.ang_accel_x  <= alpha_q[0];
      out_q.ang_accel_y  <= alpha_q[1];
      out_q.ang_accel_z  <= alpha_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("finished transaction not presented");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!pend_q && !cmd_i.issue))
    else $error("new sample set loaded while products are in flight");

  a_first_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> !first_q)
    else $error("first-sample flag not dropped after a load");

endmodule

// ----- src/imu_lever_arm_compensation.sv -----
// Top level: IMU lever-arm acceleration compensation.
//
//   channel   direction  handshake          payload
//   imu_i     in         valid/ready        accel_x/y/z, rate_x/y/z (Q15.16)
//   comp_o    out        valid/ready        comp_accel_x/y/z, ang_accel_x/y/z
//   cfg       in         cfg_we_i           cfg_idx_i, cfg_data_i (offsets, sample rate)
//
// A result is presented after 21 products through the single shared multiplier, one
// accumulate drain and one result write; the write waits while the output register
// still holds an untaken result, and a sample set holds the sequencer until its result is written.
// A new sample set is taken only when the sequencer is idle; a result waiting
// in the output register does not hold off acceptance, only the next write-back.
// Reset clears the rate history, raises the first-sample flag and restores register defaults.
module imu_lever_arm_compensation #(
  parameter int DATA_WIDTH = ilac_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = ilac_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ilac_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ilac_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ilac_in_if.sink                         imu_i,
  ilac_out_if.source                      comp_o
);

  ilac_pkg::ctrl_cmd_t cmd;
  ilac_pkg::dp_stat_t  stat;

  ilac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (imu_i.valid),
    .in_ready_o (imu_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ilac_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (imu_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (comp_o.valid),
    .out_ready_i (comp_o.ready),
    .out_data_o  (comp_o.data)
  );

endmodule

// ----- sim/ilac_checker.sv -----
// Checker for lever-arm compensation: predicts each result and compares transactions.
module ilac_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ilac_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ilac_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ilac_in_if                              imu_i,
  ilac_out_if                             comp_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import ilac_pkg::*;

  localparam int     FRAC   = FRAC_BITS_DEF;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam int     MAX_REPORTS = 10;

  string field_name [6] = '{"comp_accel_x", "comp_accel_y", "comp_accel_z",
                            "ang_accel_x", "ang_accel_y", "ang_accel_z"};

  logic signed [OFFSET_W-1:0] arm_q [3];
  logic [HZ_W-1:0]            hz_q;
  logic signed [FIELD_W-1:0]  last_rate_q [3];
  logic                       first_q;
  out_item_t                  predicted_comp_q [$];
  int                         mismatches;
  int                         reported;
  int                         result_idx;

  function automatic longint clamp32(input longint x);
    if (x > SAT_HI) return SAT_HI;
    if (x < SAT_LO) return SAT_LO;
    return x;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    longint p;
    p = a * b + (longint'(1) <<< (FRAC - 1));
    return p >>> FRAC;
  endfunction

  function automatic out_item_t compensate(input in_item_t s);
    longint    acc [3];
    longint    w [3];
    longint    r [3];
    longint    alpha [3];
    longint    tang [3];
    longint    wr [3];
    longint    cen [3];
    longint    comp [3];
    int        j;
    int        k;
    out_item_t o;
    acc[0] = longint'(s.accel_x);
    acc[1] = longint'(s.accel_y);
    acc[2] = longint'(s.accel_z);
    w[0]   = longint'(s.rate_x);
    w[1]   = longint'(s.rate_y);
    w[2]   = longint'(s.rate_z);
    for (int i = 0; i < 3; i++) begin
      r[i] = longint'(arm_q[i]);
      if (first_q) begin
        alpha[i] = 0;
      end else begin
        alpha[i] = clamp32((w[i] - longint'(last_rate_q[i])) * longint'(hz_q));
      end
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      tang[i] = qmul(alpha[j], r[k]) - qmul(alpha[k], r[j]);
      wr[i]   = clamp32(qmul(w[j], r[k]) - qmul(w[k], r[j]));
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      cen[i]  = qmul(w[j], wr[k]) - qmul(w[k], wr[j]);
      comp[i] = clamp32(acc[i] - (tang[i] + cen[i]));
    end
    o.comp_accel_x = 32'(comp[0]);
    o.comp_accel_y = 32'(comp[1]);
    o.comp_accel_z = 32'(comp[2]);
    o.ang_accel_x  = 32'(alpha[0]);
    o.ang_accel_y  = 32'(alpha[1]);
    o.ang_accel_z  = 32'(alpha[2]);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_b
    out_item_t    want;
    logic [191:0] want_bits;
    logic [191:0] got_bits;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        arm_q[i]       = '0;
        last_rate_q[i] = '0;
      end
      hz_q    = HZ_RESET;
      first_q = 1'b1;
      predicted_comp_q.delete();
      mismatches   = 0;
      reported     = 0;
      result_idx   = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OFFSET_X: arm_q[0] = cfg_data_i[OFFSET_W-1:0];
          CFG_OFFSET_Y: arm_q[1] = cfg_data_i[OFFSET_W-1:0];
          CFG_OFFSET_Z: arm_q[2] = cfg_data_i[OFFSET_W-1:0];
          CFG_RATE_HZ:  hz_q     = cfg_data_i[HZ_W-1:0];
          default: ;
        endcase
      end
      if (comp_i.valid && comp_i.ready) begin
        if (predicted_comp_q.size() == 0) begin
          mismatches++;
          if (reported < MAX_REPORTS) begin
            $display("unexpected result %0d: %h", result_idx, comp_i.data);
            reported++;
          end
        end else begin
          want      = predicted_comp_q.pop_front();
          want_bits = want;
          got_bits  = comp_i.data;
          for (int f = 0; f < 6; f++) begin
            if (got_bits[191-32*f -: 32] !== want_bits[191-32*f -: 32]) begin
              mismatches++;
              if (reported < MAX_REPORTS) begin
                $display("result %0d %s: expected %h, got %h", result_idx, field_name[f],
                         want_bits[191-32*f -: 32], got_bits[191-32*f -: 32]);
                reported++;
              end
            end
          end
        end
        result_idx++;
      end
      if (imu_i.valid && imu_i.ready) begin
        predicted_comp_q.push_back(compensate(imu_i.data));
        last_rate_q[0] = imu_i.data.rate_x;
        last_rate_q[1] = imu_i.data.rate_y;
        last_rate_q[2] = imu_i.data.rate_z;
        first_q        = 1'b0;
      end
      pending_o    <= predicted_comp_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for lever-arm compensation: clock, reset, stimulus and verdict.
module tb_top;
  import ilac_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int NUM_RANDOM  = 850;
  localparam int NUM_PHASES  = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 30;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    cycle_cnt;
  int                    hold_cnt;
  bit                    quiet;
  bit                    calm;
  bit                    hold_req;
  logic signed [31:0]    rate_hist [3];

  ilac_in_if  imu_ch ();
  ilac_out_if comp_ch ();

  imu_lever_arm_compensation uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .imu_i      (imu_ch),
    .comp_o     (comp_ch)
  );

  ilac_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .imu_i        (imu_ch),
    .comp_i       (comp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic in_item_t sample(input logic [31:0] ax, input logic [31:0] ay,
                                      input logic [31:0] az, input logic [31:0] rx,
                                      input logic [31:0] ry, input logic [31:0] rz);
    in_item_t s;
    s.accel_x = ax;
    s.accel_y = ay;
    s.accel_z = az;
    s.rate_x  = rx;
    s.rate_y  = ry;
    s.rate_z  = rz;
    return s;
  endfunction

  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3, 4, 5: return $urandom;
      default: return 32'($urandom_range(0, 32'h003fffff)) - 32'h00200000;
    endcase
  endfunction

  function automatic in_item_t random_sample();
    logic [31:0] acc [3];
    logic [31:0] rate [3];
    logic [31:0] base;
    if ($urandom_range(0, 9) < 7) begin
      for (int i = 0; i < 3; i++) begin
        base = rate_hist[i];
        if ($signed(base) > 32'sd4194304 || $signed(base) < -32'sd4194304) begin
          base = 32'h0;
        end
        acc[i]  = 32'($urandom_range(0, 32'h007fffff)) - 32'h00400000;
        rate[i] = base + 32'($urandom_range(0, 8191)) - 32'd4096;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        acc[i]  = any_word();
        rate[i] = any_word();
      end
    end
    return sample(acc[0], acc[1], acc[2], rate[0], rate[1], rate[2]);
  endfunction

  function automatic logic [19:0] random_arm();
    case ($urandom_range(0, 5))
      0: return 20'h7ffff;
      1: return 20'h80000;
      2: return 20'($urandom);
      default: return 20'($urandom_range(0, 20'h3ffff)) - 20'h20000;
    endcase
  endfunction

  function automatic logic [15:0] random_hz();
    case ($urandom_range(0, 6))
      0: return 16'd1;
      1: return 16'hffff;
      2: return 16'd0;
      3: return 16'd1000;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic offer(input in_item_t s);
    imu_ch.valid <= 1'b1;
    imu_ch.data  <= s;
    do @(posedge clk_i); while (!imu_ch.ready);
    rate_hist[0] = s.rate_x;
    rate_hist[1] = s.rate_y;
    rate_hist[2] = s.rate_z;
  endtask

  task automatic sender_gap();
    if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
      imu_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic send(input in_item_t s);
    sender_gap();
    offer(s);
  endtask

  task automatic drain();
    imu_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic program_regs(input logic [19:0] ox, input logic [19:0] oy,
                              input logic [19:0] oz, input logic [15:0] hz);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_OFFSET_X;
    cfg_data <= ox;
    @(posedge clk_i);
    cfg_idx  <= CFG_OFFSET_Y;
    cfg_data <= oy;
    @(posedge clk_i);
    cfg_idx  <= CFG_OFFSET_Z;
    cfg_data <= oz;
    @(posedge clk_i);
    cfg_idx  <= CFG_RATE_HZ;
    cfg_data <= {4'h0, hz};
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    comp_ch.ready = 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        comp_ch.ready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(posedge clk_i);
          hold_cnt++;
        end
        comp_ch.ready <= 1'b1;
      end else if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
        comp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        comp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_OFFSET_X;
    cfg_data     = '0;
    imu_ch.valid = 1'b0;
    imu_ch.data  = '0;
    quiet        = 1'b0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    for (int i = 0; i < 3; i++) rate_hist[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(sample(32'h00010000, 32'hffff0000, 32'h0009cf5c,
                32'h7fffffff, 32'h80000000, 32'h12345678));
    send(sample(32'h7fffffff, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0));
    send(sample(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    drain();

    program_regs(20'h18000, 20'hf4000, 20'h04000, 16'd1000);
    send(sample(32'h0, 32'h0, 32'h0009cf5c, 32'h0, 32'h0, 32'h00010000));
    send(sample(32'h00001000, 32'hfff00000, 32'h0009cf5c, 32'h00008000, 32'h0, 32'h00020000));
    send(sample(32'h80000000, 32'h80000000, 32'h80000000,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send(sample(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h80000000, 32'h80000000, 32'h80000000));
    send(sample(32'haaaaaaaa, 32'h55555555, 32'hffffffff,
                32'haaaaaaaa, 32'h55555555, 32'hffffffff));
    send(sample(32'h55555555, 32'haaaaaaaa, 32'h00000001,
                32'h55555555, 32'haaaaaaaa, 32'h00000001));
    drain();

    program_regs(20'h7ffff, 20'h80000, 20'h7ffff, 16'hffff);
    send(sample(32'h0, 32'h0, 32'h0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send(sample(32'h0, 32'h0, 32'h0, 32'h80000000, 32'h80000000, 32'h80000000));
    send(sample(32'h80000000, 32'h7fffffff, 32'h0, 32'h0, 32'h0, 32'h0));
    send(sample(32'h00010000, 32'h00010000, 32'h00010000,
                32'h00000001, 32'hffffffff, 32'h00000002));
    drain();

    program_regs(20'h80000, 20'h7ffff, 20'h80000, 16'd1);
    send(sample(32'h0, 32'h0, 32'h0, 32'h00010000, 32'hffff0000, 32'h7fffffff));
    send(sample(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                32'h80000000, 32'h7fffffff, 32'h80000000));
    send(sample(32'h0, 32'h0, 32'h0, 32'h00000001, 32'h00000001, 32'h00000001));
    drain();

    program_regs(20'h01000, 20'hff000, 20'h00800, 16'd0);
    send(sample(32'h00020000, 32'h0, 32'h0, 32'h7fffffff, 32'h0, 32'h80000000));
    send(sample(32'h0, 32'h00020000, 32'h0, 32'h80000000, 32'h7fffffff, 32'h0));
    send(sample(32'h0, 32'h0, 32'h00020000, 32'h00030000, 32'h00010000, 32'h00020000));
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      program_regs(random_arm(), random_arm(), random_arm(), random_hz());
      quiet = ($urandom_range(0, 3) == 0);
      if (p == 1) hold_req = 1'b1;
      if (p == NUM_PHASES - 1) calm = 1'b1;
      for (int n = 0; n < NUM_RANDOM / NUM_PHASES; n++) send(random_sample());
      drain();
    end

    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
